>>> design/cmm_pkg.sv
// Shared constants, state and operation codes for the confusion-matrix metrics block.
// No dependencies; imported by every module of the block.
package cmm_pkg;

	localparam int MAX_CLASSES_DEF = 16;
	localparam int LABEL_W         = 8;
	localparam int CFG_W           = 5;
	localparam int CNT_W           = 32;
	localparam int FRAC_W          = 16;
	localparam int RATIO_W         = FRAC_W + 1;
	localparam int IDX_W           = 4;
	localparam int CFG_RESET       = 16;
	localparam int IN_DATA_W       = 2 * LABEL_W;
	localparam int OUT_DATA_W      = IDX_W + 4 * RATIO_W + CNT_W;

	localparam logic [CNT_W-1:0]   CNT_SAT = '1;
	localparam logic [RATIO_W-1:0] Q_ONE   = RATIO_W'(1) << FRAC_W;

	// Opcode carried in tuser
	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_FINISH = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAIN,
		ST_DIAG,
		ST_ROW,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_PREC,
		OP_REC,
		OP_F1
	} div_op_t;

	// Control from the sequencer to the count store
	typedef struct packed {
		logic sample;
		logic clear;
	} store_ctl_t;

endpackage

>>> design/cmm_store.sv
// Count store: confusion matrix and class supports in synchronous memories.
// Sample words update by read-modify-write with one-back forwarding. Uses cmm_pkg.
module cmm_store import cmm_pkg::*; #(
	parameter int CLS_W  = 4,
	parameter int ADDR_W = 2 * CLS_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  store_ctl_t        ctl,
	input  logic [ADDR_W-1:0] smp_cell,
	input  logic [CLS_W-1:0]  smp_lab,
	input  logic [ADDR_W-1:0] clr_addr,
	input  logic [ADDR_W-1:0] rda_addr,
	input  logic [ADDR_W-1:0] rdb_addr,
	input  logic [CLS_W-1:0]  sup_addr,
	output logic [CNT_W-1:0]  rda_data,
	output logic [CNT_W-1:0]  rdb_data,
	output logic [CNT_W-1:0]  sup_data
);

	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SDEPTH = 1 << CLS_W;

	logic [CNT_W-1:0] mat_mem [DEPTH];
	logic [CNT_W-1:0] sup_mem [SDEPTH];

	logic [ADDR_W-1:0] a_addr;
	logic [CLS_W-1:0]  s_addr;
	logic [CNT_W-1:0]  rda_q, rdb_q, sup_q;

	logic              smp_v_s1;
	logic [ADDR_W-1:0] cell_s1;
	logic [CLS_W-1:0]  lab_s1;

	logic              lw_v_q;
	logic [ADDR_W-1:0] lw_cell_q;
	logic [CLS_W-1:0]  lw_lab_q;
	logic [CNT_W-1:0]  lw_mat_q, lw_sup_q;

	logic [CNT_W-1:0]  mat_cur, sup_cur, mat_new, sup_new;
	logic              we;
	logic [ADDR_W-1:0] w_addr;
	logic [CLS_W-1:0]  sw_addr;
	logic [CNT_W-1:0]  w_data, sw_data;

	// Route sample addresses onto the shared read ports
	assign a_addr = ctl.sample ? smp_cell : rda_addr;
	assign s_addr = ctl.sample ? smp_lab : sup_addr;

	// Forward the word written last cycle when it hits the same entry
	assign mat_cur = (lw_v_q && lw_cell_q == cell_s1) ? lw_mat_q : rda_q;
	assign sup_cur = (lw_v_q && lw_lab_q == lab_s1) ? lw_sup_q : sup_q;
	assign mat_new = (mat_cur == CNT_SAT) ? mat_cur : mat_cur + CNT_W'(1);
	assign sup_new = (sup_cur == CNT_SAT) ? sup_cur : sup_cur + CNT_W'(1);

	// Write port: clearing sweep or sample update
	assign we      = ctl.clear || smp_v_s1;
	assign w_addr  = ctl.clear ? clr_addr : cell_s1;
	assign w_data  = ctl.clear ? '0 : mat_new;
	assign sw_addr = ctl.clear ? clr_addr[CLS_W-1:0] : lab_s1;
	assign sw_data = ctl.clear ? '0 : sup_new;

	// Memories: registered reads, one write each
	always_ff @(posedge clk) begin
		rda_q <= mat_mem[a_addr];
		rdb_q <= mat_mem[rdb_addr];
		sup_q <= sup_mem[s_addr];
		if (we) begin
			mat_mem[w_addr] <= w_data;
			sup_mem[sw_addr] <= sw_data;
		end
	end

	// Track the sample in flight and the word last written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_v_s1 <= 1'b0;
			lw_v_q   <= 1'b0;
		end else begin
			smp_v_s1 <= ctl.sample;
			lw_v_q   <= smp_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cell_s1   <= smp_cell;
		lab_s1    <= smp_lab;
		lw_cell_q <= cell_s1;
		lw_lab_q  <= lab_s1;
		lw_mat_q  <= mat_new;
		lw_sup_q  <= sup_new;
	end

	assign rda_data = rda_q;
	assign rdb_data = rdb_q;
	assign sup_data = sup_q;

endmodule

>>> design/cmm_div.sv
// Shared ratio unit: unsigned Q1.16 quotient num/den, truncated, capped at 1.0,
// zero for a zero denominator. Restoring, one quotient bit per cycle. Uses cmm_pkg.
module cmm_div import cmm_pkg::*; #(
	parameter int DW = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DW-1:0]      num,
	input  logic [DW-1:0]      den,
	output logic               done,
	output logic [RATIO_W-1:0] quot
);

	localparam int CW = $clog2(FRAC_W + 1);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [DW:0]       rem_q;
	logic [DW-1:0]     den_q;
	logic [FRAC_W-1:0] q_q;
	logic [RATIO_W-1:0] res_q;

	logic [DW:0]       rem_sh;
	logic              take;
	logic [FRAC_W-1:0] q_nx;

	// One restoring step
	assign rem_sh = {rem_q[DW-1:0], 1'b0};
	assign take   = rem_sh >= {1'b0, den_q};
	assign q_nx   = {q_q[FRAC_W-2:0], take};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(FRAC_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: settle trivial cases at once, else iterate
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			q_q   <= '0;
			if (den == '0) begin
				res_q <= '0;
			end else if (num >= den) begin
				res_q <= Q_ONE;
			end
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
			q_q   <= q_nx;
			if (cnt_q == CW'(1)) begin
				res_q <= {1'b0, q_nx};
			end
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

>>> design/confusion_matrix_metrics_top.sv
// Confusion-matrix metrics top level: sequencer, accumulators and stream ports.
// Depends on cmm_pkg, cmm_store and cmm_div.
//
//  channel   | dir | words
//  ----------+-----+----------------------------------------------------------
//  cfg       | in  | class_count write
//  s_axis    | in  | sample (tuser 0) or finish (tuser 1), labels in tdata
//  m_axis    | out | one metrics row per class, tlast on the final class
//
// While idle, samples stream back to back through the matrix read-modify-write
// with forwarding. A finish takes a drain step, the diagonal walk and the accuracy
// divide, then per class a walk and three divides before its row goes out,
// followed by a clearing sweep over all 2^(2*clog2(MAX_CLASSES)) matrix addresses.
// The same sweep runs after reset; no word is taken on s_axis during it. A stalled
// m_axis holds the row and the walk; configuration is always taken.
module confusion_matrix_metrics_top import cmm_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,       // class_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // true_label, predicted_label
	input  logic [0:0]            s_axis_tuser,   // opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // class_index, precision_q16,
	                                              // recall_q16, f1_q16,
	                                              // class_support, accuracy_q16
	output logic                  m_axis_tlast    // last_row
);

	localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int N_W    = $clog2(MAX_CLASSES + 1);
	localparam int ADDR_W = 2 * CLS_W;
	localparam int SUM_W  = CNT_W + CLS_W;
	localparam int DW     = SUM_W + 2;

	state_t  state_q, state_nx;
	div_op_t op_q;

	logic [CFG_W-1:0]   class_count_q;
	logic [N_W-1:0]     n_eff;
	logic [CNT_W-1:0]   total_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [N_W-1:0]     kk_q, t_q;
	logic               rd_v_s1;
	logic [CLS_W-1:0]   k_s1;
	logic [SUM_W-1:0]   correct_q, fp_q, fn_q;
	logic [CNT_W-1:0]   tp_q, sup_q;
	logic [RATIO_W-1:0] acc_q, prec_q, rec_q, f1_q;

	logic                  out_v_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	logic [LABEL_W-1:0] tl, pl;
	logic               lab_ok, acc_in, smp_acc, fin_acc;
	logic               walk_end, issue, div_start, emit_load, last_cls, clr_end;
	logic [CLS_W-1:0]   k, t;
	store_ctl_t         ctl;
	logic [ADDR_W-1:0]  rda_addr, rdb_addr;
	logic [CNT_W-1:0]   rda_data, rdb_data, sup_data;
	logic [DW-1:0]      div_num, div_den;
	logic               div_done;
	logic [RATIO_W-1:0] div_quot;
	logic [CLS_W+IDX_W-1:0] t_ext;

	assign n_eff = (int'(class_count_q) > MAX_CLASSES) ? N_W'(MAX_CLASSES)
	                                                  : N_W'(class_count_q);

	// Input decode
	assign tl      = s_axis_tdata[LABEL_W-1:0];
	assign pl      = s_axis_tdata[IN_DATA_W-1:LABEL_W];
	assign lab_ok  = !tl[LABEL_W-1] && !pl[LABEL_W-1] &&
	                 (tl < LABEL_W'(n_eff)) && (pl < LABEL_W'(n_eff));
	assign acc_in  = s_axis_tvalid && s_axis_tready;
	assign smp_acc = acc_in && (s_axis_tuser[0] == OPC_SAMPLE);
	assign fin_acc = acc_in && (s_axis_tuser[0] == OPC_FINISH);

	assign k        = kk_q[CLS_W-1:0];
	assign t        = t_q[CLS_W-1:0];
	assign walk_end = (kk_q == n_eff);
	assign last_cls = (t_q + N_W'(1) == n_eff);
	assign clr_end  = (clr_q == '1);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:    if (clr_end) state_nx = ST_IDLE;
			ST_IDLE:     if (fin_acc) state_nx = ST_DRAIN;
			ST_DRAIN:    state_nx = (n_eff == '0) ? ST_CLEAR : ST_DIAG;
			ST_DIAG:     if (walk_end) state_nx = ST_DIV_GO;
			ST_ROW:      if (walk_end) state_nx = ST_DIV_GO;
			ST_DIV_GO:   state_nx = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					unique case (op_q)
						OP_ACC:  state_nx = ST_ROW;
						OP_F1:   state_nx = ST_EMIT;
						default: state_nx = ST_DIV_GO;
					endcase
				end
			end
			ST_EMIT:     if (emit_load) state_nx = last_cls ? ST_CLEAR : ST_ROW;
			default:     state_nx = ST_CLEAR;
		endcase
	end

	// State outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ctl.sample    = smp_acc && lab_ok;
		ctl.clear     = 1'b0;
		issue         = 1'b0;
		div_start     = 1'b0;
		emit_load     = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_CLEAR:  ctl.clear = 1'b1;
			ST_DIAG,
			ST_ROW:    issue = !walk_end;
			ST_DIV_GO: div_start = 1'b1;
			ST_EMIT:   emit_load = !out_v_q || m_axis_tready;
			default:   ;
		endcase
	end

	assign cfg_ready  = 1'b1;

	// Walk addresses: diagonal, then row t (fn) and column t (fp)
	assign rda_addr = (state_q == ST_DIAG) ? {k, k} : {t, k};
	assign rdb_addr = {k, t};

	cmm_store #(
		.CLS_W  (CLS_W),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.smp_cell ({tl[CLS_W-1:0], pl[CLS_W-1:0]}),
		.smp_lab  (tl[CLS_W-1:0]),
		.clr_addr (clr_q),
		.rda_addr (rda_addr),
		.rdb_addr (rdb_addr),
		.sup_addr (t),
		.rda_data (rda_data),
		.rdb_data (rdb_data),
		.sup_data (sup_data)
	);

	// Divider operands
	always_comb begin
		unique case (op_q)
			OP_ACC: begin
				div_num = DW'(correct_q);
				div_den = DW'(total_q);
			end
			OP_PREC: begin
				div_num = DW'(tp_q);
				div_den = DW'(tp_q) + DW'(fp_q);
			end
			OP_REC: begin
				div_num = DW'(tp_q);
				div_den = DW'(tp_q) + DW'(fn_q);
			end
			default: begin
				div_num = DW'(tp_q) << 1;
				div_den = (DW'(tp_q) << 1) + DW'(fp_q) + DW'(fn_q);
			end
		endcase
	end

	cmm_div #(
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			class_count_q <= CFG_W'(CFG_RESET);
			total_q       <= '0;
			clr_q         <= '0;
			kk_q          <= '0;
			t_q           <= '0;
			rd_v_s1       <= 1'b0;
			op_q          <= OP_ACC;
			out_v_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				class_count_q <= cfg_data;
			end
			// Saturating sample total; cleared by the sweep
			if (ctl.clear) begin
				total_q <= '0;
			end else if (smp_acc && total_q != CNT_SAT) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (ctl.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			// Walk counter and read-valid pipe
			if (state_q == ST_DIAG || state_q == ST_ROW) begin
				kk_q <= walk_end ? '0 : kk_q + N_W'(1);
			end
			rd_v_s1 <= issue;
			if (state_q == ST_DRAIN) begin
				t_q  <= '0;
				kk_q <= '0;
			end
			if (state_q == ST_DIAG && walk_end) begin
				op_q <= OP_ACC;
			end
			if (state_q == ST_ROW && walk_end) begin
				op_q <= OP_PREC;
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				unique case (op_q)
					OP_PREC: op_q <= OP_REC;
					OP_REC:  op_q <= OP_F1;
					default: op_q <= op_q;
				endcase
			end
			if (emit_load) begin
				t_q <= t_q + N_W'(1);
			end
			// Output register
			if (emit_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign t_ext = {{IDX_W{1'b0}}, t};

	// Accumulators and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			correct_q <= '0;
		end
		if (state_q == ST_DIAG && rd_v_s1) begin
			correct_q <= correct_q + SUM_W'(rda_data);
		end
		if (state_q == ST_ROW && kk_q == '0) begin
			tp_q <= '0;
			fp_q <= '0;
			fn_q <= '0;
		end else if (state_q == ST_ROW && rd_v_s1) begin
			if (k_s1 == t) begin
				tp_q <= rda_data;
			end else begin
				fn_q <= fn_q + SUM_W'(rda_data);
				fp_q <= fp_q + SUM_W'(rdb_data);
			end
		end
		if (state_q == ST_ROW && walk_end) begin
			sup_q <= sup_data;
		end
		k_s1 <= k;
		if (state_q == ST_DIV_WAIT && div_done) begin
			unique case (op_q)
				OP_ACC:  acc_q  <= div_quot;
				OP_PREC: prec_q <= div_quot;
				OP_REC:  rec_q  <= div_quot;
				default: f1_q   <= div_quot;
			endcase
		end
		if (emit_load) begin
			out_data_q <= {acc_q, sup_q, f1_q, rec_q, prec_q, t_ext[IDX_W-1:0]};
			out_last_q <= last_cls;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> tb/sv/confusion_matrix_metrics_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for confusion_matrix_metrics_top: streams samples and finishes,
// predicts the per-class metrics rows and compares them word by word. Depends on cmm_pkg.
module confusion_matrix_metrics_top_tb;
	import cmm_pkg::*;

	localparam int NCLS = MAX_CLASSES_DEF;
	localparam int SETTLE = 3000;

	typedef struct packed {
		logic       opc;
		logic [7:0] tl;
		logic [7:0] pl;
	} label_word_t;

	typedef struct packed {
		logic [RATIO_W-1:0] acc;
		logic [CNT_W-1:0]   sup;
		logic [RATIO_W-1:0] f1;
		logic [RATIO_W-1:0] rec;
		logic [RATIO_W-1:0] prec;
		logic [IDX_W-1:0]   idx;
		logic               last;
	} metrics_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	label_word_t  pending_words[$];
	metrics_row_t expected_rows[$];
	logic [CNT_W-1:0] cell_cnt[NCLS][NCLS];
	logic [CNT_W-1:0] class_sup[NCLS];
	logic [CNT_W-1:0] total_cnt;
	logic [CFG_W-1:0] class_count_m;
	int  words_queued = 0;
	int  words_taken = 0;
	int  errors = 0;
	logic word_taken = 1'b0;
	int  burst_left = 4;
	int  gap_left = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	int  stall_tick = 0;

	always #2 clk = ~clk;

	confusion_matrix_metrics_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// truncated Q1.16 ratio, zero on an empty denominator, capped at one
	function automatic logic [RATIO_W-1:0] q16_div(longint unsigned num, longint unsigned den);
		longint unsigned r;
		if (den == 0) return '0;
		r = (num << FRAC_W) / den;
		return (r > 65536) ? Q_ONE : RATIO_W'(r);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add1(logic [CNT_W-1:0] v);
		return (v == CNT_SAT) ? v : v + 1'b1;
	endfunction

	// update the counts for one word, or emit the rows of a finish and clear
	task automatic predict_metrics(label_word_t w);
		int n;
		int t;
		int k;
		longint unsigned diag;
		longint unsigned tp;
		longint unsigned fp;
		longint unsigned fn;
		logic [RATIO_W-1:0] acc;
		metrics_row_t row;
		n = (class_count_m > NCLS) ? NCLS : int'(class_count_m);
		if (w.opc == OPC_SAMPLE) begin
			total_cnt = sat_add1(total_cnt);
			if ($signed(w.tl) >= 0 && $signed(w.pl) >= 0 && int'(w.tl) < n && int'(w.pl) < n) begin
				cell_cnt[w.tl][w.pl] = sat_add1(cell_cnt[w.tl][w.pl]);
				class_sup[w.tl] = sat_add1(class_sup[w.tl]);
			end
		end else begin
			diag = 0;
			for (t = 0; t < n; t++) diag += cell_cnt[t][t];
			acc = q16_div(diag, total_cnt);
			for (t = 0; t < n; t++) begin
				tp = cell_cnt[t][t];
				fp = 0;
				fn = 0;
				for (k = 0; k < n; k++) if (k != t) begin
					fp += cell_cnt[k][t];
					fn += cell_cnt[t][k];
				end
				row.idx  = IDX_W'(t);
				row.prec = q16_div(tp, tp + fp);
				row.rec  = q16_div(tp, tp + fn);
				row.f1   = q16_div(2 * tp, 2 * tp + fp + fn);
				row.sup  = class_sup[t];
				row.acc  = acc;
				row.last = (t == n - 1);
				expected_rows.push_back(row);
			end
			for (t = 0; t < NCLS; t++) begin
				class_sup[t] = '0;
				for (k = 0; k < NCLS; k++) cell_cnt[t][k] = '0;
			end
			total_cnt = '0;
		end
	endtask

	// sample both channels and the config write at the rising edge
	always @(posedge clk) begin
		metrics_row_t exp_row;
		label_word_t w;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (cfg_valid && cfg_ready) class_count_m = cfg_data;
		if (s_axis_tvalid && s_axis_tready) begin
			w.opc = s_axis_tuser[0];
			w.tl  = s_axis_tdata[7:0];
			w.pl  = s_axis_tdata[15:8];
			predict_metrics(w);
			words_taken++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_rows.size() == 0) begin
				$error("unexpected metrics row %h", m_axis_tdata);
				errors++;
			end else begin
				exp_row = expected_rows.pop_front();
				if (m_axis_tdata[3:0] !== exp_row.idx) begin
					$error("class_index exp %0d got %0d", exp_row.idx, m_axis_tdata[3:0]);
					errors++;
				end
				if (m_axis_tdata[20:4] !== exp_row.prec) begin
					$error("precision_q16 exp %0d got %0d", exp_row.prec, m_axis_tdata[20:4]);
					errors++;
				end
				if (m_axis_tdata[37:21] !== exp_row.rec) begin
					$error("recall_q16 exp %0d got %0d", exp_row.rec, m_axis_tdata[37:21]);
					errors++;
				end
				if (m_axis_tdata[54:38] !== exp_row.f1) begin
					$error("f1_q16 exp %0d got %0d", exp_row.f1, m_axis_tdata[54:38]);
					errors++;
				end
				if (m_axis_tdata[86:55] !== exp_row.sup) begin
					$error("class_support exp %0d got %0d", exp_row.sup, m_axis_tdata[86:55]);
					errors++;
				end
				if (m_axis_tdata[103:87] !== exp_row.acc) begin
					$error("accuracy_q16 exp %0d got %0d", exp_row.acc, m_axis_tdata[103:87]);
					errors++;
				end
				if (m_axis_tlast !== exp_row.last) begin
					$error("last_row exp %0d got %0d", exp_row.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// advance the sender in bursts with random gaps
	always @(negedge clk) begin
		label_word_t w;
		logic drive;
		drive = s_axis_tvalid && !word_taken;
		if (!drive) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				s_axis_tdata <= {w.pl, w.tl};
				s_axis_tuser <= w.opc;
				drive = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		s_axis_tvalid <= drive;
	end

	// stall the receiver on a rotating pattern, reselected now and then
	always @(negedge clk) begin
		if (stall_tick == 63) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'h00FF;
				default: stall_pat = 16'($urandom);
			endcase
		end
		stall_tick = (stall_tick + 1) % 64;
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		m_axis_tready <= stall_pat[0] | (stall_pat == 16'h0);
	end

	task automatic queue_word(logic opc, logic [7:0] tl, logic [7:0] pl);
		label_word_t w;
		w.opc = opc;
		w.tl = tl;
		w.pl = pl;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// hold until every word is taken and every row is back, then let the block settle
	task automatic wait_drained(int extra);
		do @(negedge clk);
		while (pending_words.size() != 0 || words_taken != words_queued
			|| expected_rows.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_class_count(logic [CFG_W-1:0] v);
		wait_drained(SETTLE);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// well-formed labels with some noise, closed by a finish
	task automatic queue_batch(int n_cls, int len);
		int i;
		int lim;
		lim = (n_cls < 1) ? 1 : n_cls;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_word(OPC_SAMPLE, 8'($urandom), 8'($urandom));
			else
				queue_word(OPC_SAMPLE, 8'($urandom_range(0, lim - 1)),
					8'($urandom_range(0, lim - 1)));
		end
		queue_word(OPC_FINISH, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int p;
		int cc;
		class_count_m = CFG_W'(CFG_RESET);
		total_cnt = '0;
		for (int a = 0; a < NCLS; a++) begin
			class_sup[a] = '0;
			for (int b = 0; b < NCLS; b++) cell_cnt[a][b] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes of the labels at the reset class count, then an empty finish
		queue_word(OPC_SAMPLE, 8'd0, 8'd0);
		queue_word(OPC_SAMPLE, 8'd15, 8'd15);
		queue_word(OPC_SAMPLE, 8'd0, 8'd15);
		queue_word(OPC_SAMPLE, 8'd15, 8'd0);
		queue_word(OPC_SAMPLE, 8'h80, 8'd3);
		queue_word(OPC_SAMPLE, 8'd3, 8'hFF);
		queue_word(OPC_SAMPLE, 8'd16, 8'd2);
		queue_word(OPC_SAMPLE, 8'h7F, 8'h7F);
		queue_word(OPC_SAMPLE, 8'd2, 8'd2);
		queue_word(OPC_FINISH, 8'hFF, 8'h80);
		queue_word(OPC_FINISH, 8'h00, 8'h00);

		// zero classes: nothing valid, finish emits no rows
		write_class_count(5'd0);
		queue_word(OPC_SAMPLE, 8'd0, 8'd0);
		queue_word(OPC_SAMPLE, 8'd1, 8'd0);
		queue_word(OPC_FINISH, 8'd0, 8'd0);

		// above the maximum acts as the maximum
		write_class_count(5'd31);
		queue_word(OPC_SAMPLE, 8'd15, 8'd15);
		queue_word(OPC_SAMPLE, 8'd16, 8'd16);
		queue_word(OPC_FINISH, 8'd0, 8'd0);

		// one class; then the class count shrinks before the finish
		write_class_count(5'd1);
		queue_word(OPC_SAMPLE, 8'd0, 8'd0);
		queue_word(OPC_SAMPLE, 8'd0, 8'd1);
		queue_word(OPC_FINISH, 8'd0, 8'd0);
		write_class_count(5'd16);
		queue_word(OPC_SAMPLE, 8'd5, 8'd1);
		queue_word(OPC_SAMPLE, 8'd1, 8'd1);
		write_class_count(5'd3);
		queue_word(OPC_FINISH, 8'd0, 8'd0);

		// random phases at random class counts
		for (p = 0; p < 9; p++) begin
			case (p)
				0: cc = 2;
				1: cc = 16;
				2: cc = 17;
				default: cc = $urandom_range(0, 31);
			endcase
			write_class_count(CFG_W'(cc));
			queue_batch(cc > NCLS ? NCLS : cc, $urandom_range(8, 24));
			queue_batch(cc > NCLS ? NCLS : cc, $urandom_range(4, 14));
		end
		write_class_count(5'd4);
		queue_batch(4, 20);

		wait_drained(SETTLE);
		if (errors == 0)
			$display("PASS confusion_matrix_metrics_top");
		else
			$display("FAIL confusion_matrix_metrics_top");
		$finish;
	end

	// give up on a hung block
	initial begin
		#2000000;
		$display("FAIL confusion_matrix_metrics_top");
		$finish;
	end

endmodule
